### rtl/bop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bop_pkg;

    // Field width and CORDIC length
    localparam int COORD_WIDTH   = 32;
    localparam int CORDIC_STAGES = 24;

    // Internal widths: raw differences, CORDIC datapath, binary angles (2^32 per turn)
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int VEC_W  = COORD_WIDTH + 4;
    localparam int ROT_W  = COORD_WIDTH + 4;
    localparam int ANG_W  = 35;
    localparam int PROD_W = COORD_WIDTH + 31;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = 35'sh0_8000_0000;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 35'sh0_4000_0000;
    localparam logic signed [30:0]      KINV_Q30     = 31'sd652032874;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    // Sideband that rides along the vectoring pipe
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] mx;
        logic signed [COORD_WIDTH-1:0] my;
        logic signed [ROT_W-1:0]       scaled;
        logic                          a_zero;
        logic                          b_zero;
    } vec_side_t;

    // Sideband that rides along the rotation pipe
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] mx;
        logic signed [COORD_WIDTH-1:0] my;
    } rot_side_t;

endpackage

`default_nettype wire

### rtl/bop_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bop_in_if;
    logic valid;
    logic ready;
    logic signed [bop_pkg::COORD_WIDTH-1:0] first_x;
    logic signed [bop_pkg::COORD_WIDTH-1:0] first_y;
    logic signed [bop_pkg::COORD_WIDTH-1:0] middle_x;
    logic signed [bop_pkg::COORD_WIDTH-1:0] middle_y;
    logic signed [bop_pkg::COORD_WIDTH-1:0] next_x;
    logic signed [bop_pkg::COORD_WIDTH-1:0] next_y;
    logic signed [bop_pkg::COORD_WIDTH-1:0] distance;

    modport source (output valid, first_x, first_y, middle_x, middle_y, next_x, next_y,
                    distance, input ready);
    modport sink (input valid, first_x, first_y, middle_x, middle_y, next_x, next_y,
                  distance, output ready);
endinterface

interface bop_out_if;
    logic valid;
    logic ready;
    logic signed [bop_pkg::COORD_WIDTH-1:0] out_x;
    logic signed [bop_pkg::COORD_WIDTH-1:0] out_y;

    modport source (output valid, out_x, out_y, input ready);
    modport sink (input valid, out_x, out_y, output ready);
endinterface

`default_nettype wire

### rtl/bop_vectoring.sv
`timescale 1ns / 1ps
`default_nettype none

// Two vectoring CORDICs side by side, one iteration per register stage
module bop_vectoring (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire logic signed [bop_pkg::VEC_W-1:0]       ax,
    input  wire logic signed [bop_pkg::VEC_W-1:0]       ay,
    input  wire logic signed [bop_pkg::ANG_W-1:0]       az,
    input  wire logic signed [bop_pkg::VEC_W-1:0]       bx,
    input  wire logic signed [bop_pkg::VEC_W-1:0]       by,
    input  wire logic signed [bop_pkg::ANG_W-1:0]       bz,
    input  wire bop_pkg::vec_side_t                     in_side,
    output logic                                        out_valid,
    output logic signed [bop_pkg::ANG_W-1:0]            angle_a,
    output logic signed [bop_pkg::ANG_W-1:0]            angle_b,
    output bop_pkg::vec_side_t                          out_side
);

    localparam int N = bop_pkg::CORDIC_STAGES;

    logic signed [bop_pkg::VEC_W-1:0] ax_reg [N];
    logic signed [bop_pkg::VEC_W-1:0] ay_reg [N];
    logic signed [bop_pkg::ANG_W-1:0] az_reg [N];
    logic signed [bop_pkg::VEC_W-1:0] bx_reg [N];
    logic signed [bop_pkg::VEC_W-1:0] by_reg [N];
    logic signed [bop_pkg::ANG_W-1:0] bz_reg [N];
    bop_pkg::vec_side_t               side_reg [N];
    logic [N-1:0]                     valid_reg;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [bop_pkg::ANG_W-1:0] STEP =
            signed'(bop_pkg::ANG_W'(bop_pkg::ATAN_TURNS[i % 32]));

        logic signed [bop_pkg::VEC_W-1:0] axp, ayp, bxp, byp;
        logic signed [bop_pkg::ANG_W-1:0] azp, bzp;
        bop_pkg::vec_side_t               sp;
        logic                             vp;
        logic signed [bop_pkg::VEC_W-1:0] ax_next, ay_next, bx_next, by_next;
        logic signed [bop_pkg::ANG_W-1:0] az_next, bz_next;

        if (i == 0) begin : g_first
            assign axp = ax;
            assign ayp = ay;
            assign azp = az;
            assign bxp = bx;
            assign byp = by;
            assign bzp = bz;
            assign sp  = in_side;
            assign vp  = in_valid;
        end
        else begin : g_rest
            assign axp = ax_reg[i-1];
            assign ayp = ay_reg[i-1];
            assign azp = az_reg[i-1];
            assign bxp = bx_reg[i-1];
            assign byp = by_reg[i-1];
            assign bzp = bz_reg[i-1];
            assign sp  = side_reg[i-1];
            assign vp  = valid_reg[i-1];
        end

        // Rotate each vector toward the x axis
        always_comb
        begin
            if (ayp > 0)
            begin
                ax_next = axp + (ayp >>> i);
                ay_next = ayp - (axp >>> i);
                az_next = azp + STEP;
            end
            else
            begin
                ax_next = axp - (ayp >>> i);
                ay_next = ayp + (axp >>> i);
                az_next = azp - STEP;
            end
            if (byp > 0)
            begin
                bx_next = bxp + (byp >>> i);
                by_next = byp - (bxp >>> i);
                bz_next = bzp + STEP;
            end
            else
            begin
                bx_next = bxp - (byp >>> i);
                by_next = byp + (bxp >>> i);
                bz_next = bzp - STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= vp;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ax_reg[i]   <= ax_next;
                ay_reg[i]   <= ay_next;
                az_reg[i]   <= az_next;
                bx_reg[i]   <= bx_next;
                by_reg[i]   <= by_next;
                bz_reg[i]   <= bz_next;
                side_reg[i] <= sp;
            end
        end
    end

    // Zero vectors give angle zero
    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign angle_a   = side_reg[N-1].a_zero ? '0 : az_reg[N-1];
    assign angle_b   = side_reg[N-1].b_zero ? '0 : bz_reg[N-1];

endmodule

`default_nettype wire

### rtl/bop_rotation.sv
`timescale 1ns / 1ps
`default_nettype none

// Rotation CORDIC, one iteration per register stage
module bop_rotation (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic signed [bop_pkg::ROT_W-1:0]   x0,
    input  wire logic signed [bop_pkg::ANG_W-1:0]   a0,
    input  wire bop_pkg::rot_side_t                 in_side,
    output logic                                    out_valid,
    output logic signed [bop_pkg::ROT_W-1:0]        x,
    output logic signed [bop_pkg::ROT_W-1:0]        y,
    output bop_pkg::rot_side_t                      out_side
);

    localparam int N = bop_pkg::CORDIC_STAGES;

    logic signed [bop_pkg::ROT_W-1:0] x_reg [N];
    logic signed [bop_pkg::ROT_W-1:0] y_reg [N];
    logic signed [bop_pkg::ANG_W-1:0] a_reg [N];
    bop_pkg::rot_side_t               side_reg [N];
    logic [N-1:0]                     valid_reg;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [bop_pkg::ANG_W-1:0] STEP =
            signed'(bop_pkg::ANG_W'(bop_pkg::ATAN_TURNS[i % 32]));

        logic signed [bop_pkg::ROT_W-1:0] xp, yp, x_next, y_next;
        logic signed [bop_pkg::ANG_W-1:0] ap, a_next;
        bop_pkg::rot_side_t               sp;
        logic                             vp;

        if (i == 0) begin : g_first
            assign xp = x0;
            assign yp = '0;
            assign ap = a0;
            assign sp = in_side;
            assign vp = in_valid;
        end
        else begin : g_rest
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign ap = a_reg[i-1];
            assign sp = side_reg[i-1];
            assign vp = valid_reg[i-1];
        end

        // Turn the vector by the residual angle sign
        always_comb
        begin
            if (ap >= 0)
            begin
                x_next = xp - (yp >>> i);
                y_next = yp + (xp >>> i);
                a_next = ap - STEP;
            end
            else
            begin
                x_next = xp + (yp >>> i);
                y_next = yp - (xp >>> i);
                a_next = ap + STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= vp;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                a_reg[i]    <= a_next;
                side_reg[i] <= sp;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign x         = x_reg[N-1];
    assign y         = y_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

### rtl/bisector_offset_point.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat fields
// in_ch     in   first_x/y, middle_x/y, next_x/y, distance (signed Q16.16)
// out_ch    out  out_x, out_y (signed Q16.16, saturated)
//
// One beat enters per cycle while the output register is empty or taken; the path
// holds one register per CORDIC iteration in the vectoring and the rotation pipes,
// plus the difference, bisector and output registers.
// Reset clears only the valid bits of every stage.
// The whole pipe advances together whenever the output register is empty or taken;
// a stall freezes every stage, so no beat is lost or repeated.
module bisector_offset_point (
    input wire logic   clk,
    input wire logic   rst_n,
    bop_in_if.sink     in_ch,
    bop_out_if.source  out_ch
);

    localparam int CW = bop_pkg::COORD_WIDTH;

    logic en;
    logic out_valid_reg;
    logic signed [CW-1:0] out_x_reg, out_y_reg;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // Stage 1: differences and distance scaling product
    logic                                 s1_valid_reg;
    logic signed [bop_pkg::DIFF_W-1:0]    dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [CW-1:0]                 mx_reg, my_reg;
    logic signed [bop_pkg::PROD_W-1:0]    prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax_reg  <= bop_pkg::DIFF_W'(in_ch.next_x) - bop_pkg::DIFF_W'(in_ch.middle_x);
            day_reg  <= bop_pkg::DIFF_W'(in_ch.next_y) - bop_pkg::DIFF_W'(in_ch.middle_y);
            dbx_reg  <= bop_pkg::DIFF_W'(in_ch.first_x) - bop_pkg::DIFF_W'(in_ch.middle_x);
            dby_reg  <= bop_pkg::DIFF_W'(in_ch.first_y) - bop_pkg::DIFF_W'(in_ch.middle_y);
            mx_reg   <= in_ch.middle_x;
            my_reg   <= in_ch.middle_y;
            prod_reg <= bop_pkg::PROD_W'(in_ch.distance) * bop_pkg::PROD_W'(bop_pkg::KINV_Q30);
        end
    end

    // Pre-rotate into the right half plane
    logic signed [bop_pkg::VEC_W-1:0] ax, ay, bx, by;
    logic signed [bop_pkg::ANG_W-1:0] az, bz;
    logic signed [bop_pkg::PROD_W-1:0] prod_rnd;
    bop_pkg::vec_side_t vside;

    always_comb
    begin
        ax = bop_pkg::VEC_W'(dax_reg);
        ay = bop_pkg::VEC_W'(day_reg);
        az = '0;
        if (dax_reg < 0)
        begin
            az = (day_reg >= 0) ? bop_pkg::HALF_TURN : -bop_pkg::HALF_TURN;
            ax = -ax;
            ay = -ay;
        end
        bx = bop_pkg::VEC_W'(dbx_reg);
        by = bop_pkg::VEC_W'(dby_reg);
        bz = '0;
        if (dbx_reg < 0)
        begin
            bz = (dby_reg >= 0) ? bop_pkg::HALF_TURN : -bop_pkg::HALF_TURN;
            bx = -bx;
            by = -by;
        end
        prod_rnd      = prod_reg + (bop_pkg::PROD_W'(1) <<< 29);
        vside.mx      = mx_reg;
        vside.my      = my_reg;
        vside.scaled  = bop_pkg::ROT_W'(prod_rnd >>> 30);
        vside.a_zero  = (dax_reg == 0) && (day_reg == 0);
        vside.b_zero  = (dbx_reg == 0) && (dby_reg == 0);
    end

    logic                             v_valid;
    logic signed [bop_pkg::ANG_W-1:0] a1, a2;
    bop_pkg::vec_side_t               v_side;

    bop_vectoring u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .ax        (ax),
        .ay        (ay),
        .az        (az),
        .bx        (bx),
        .by        (by),
        .bz        (bz),
        .in_side   (vside),
        .out_valid (v_valid),
        .angle_a   (a1),
        .angle_b   (a2),
        .out_side  (v_side)
    );

    // Bisector angle, wrap and fold into the right half plane
    logic signed [bop_pkg::ANG_W:0]   a2_adj;
    logic signed [bop_pkg::ANG_W+1:0] a_sum;
    logic signed [31:0]               a_wrap;
    logic signed [bop_pkg::ANG_W-1:0] a_next, a_w;
    logic signed [bop_pkg::ROT_W-1:0] x_next;

    always_comb
    begin
        a2_adj = (a2 < a1) ? ((bop_pkg::ANG_W+1)'(a2) + (bop_pkg::ANG_W+1)'(36'sh1_0000_0000))
                           : (bop_pkg::ANG_W+1)'(a2);
        a_sum  = (bop_pkg::ANG_W+2)'(a1) + (bop_pkg::ANG_W+2)'(a2_adj);
        a_wrap = a_sum[32:1];
        a_w    = bop_pkg::ANG_W'(a_wrap);
        a_next = a_w;
        x_next = v_side.scaled;
        if (a_w > bop_pkg::QUARTER_TURN)
        begin
            x_next = -v_side.scaled;
            a_next = a_w - bop_pkg::HALF_TURN;
        end
        else if (a_w < -bop_pkg::QUARTER_TURN)
        begin
            x_next = -v_side.scaled;
            a_next = a_w + bop_pkg::HALF_TURN;
        end
    end

    logic                             c_valid_reg;
    logic signed [bop_pkg::ANG_W-1:0] c_a_reg;
    logic signed [bop_pkg::ROT_W-1:0] c_x_reg;
    bop_pkg::rot_side_t               c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= v_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_a_reg       <= a_next;
            c_x_reg       <= x_next;
            c_side_reg.mx <= v_side.mx;
            c_side_reg.my <= v_side.my;
        end
    end

    logic                             r_valid;
    logic signed [bop_pkg::ROT_W-1:0] r_x, r_y;
    bop_pkg::rot_side_t               r_side;

    bop_rotation u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .x0        (c_x_reg),
        .a0        (c_a_reg),
        .in_side   (c_side_reg),
        .out_valid (r_valid),
        .x         (r_x),
        .y         (r_y),
        .out_side  (r_side)
    );

    // Move the vertex back along the bisector and saturate
    localparam logic signed [bop_pkg::ROT_W:0] SAT_HI = (bop_pkg::ROT_W+1)'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [bop_pkg::ROT_W:0] SAT_LO = -SAT_HI - 1;

    logic signed [bop_pkg::ROT_W:0] ox_full, oy_full;
    logic signed [CW-1:0]           ox_sat, oy_sat;

    always_comb
    begin
        ox_full = (bop_pkg::ROT_W+1)'(r_side.mx) - (bop_pkg::ROT_W+1)'(r_x);
        oy_full = (bop_pkg::ROT_W+1)'(r_side.my) - (bop_pkg::ROT_W+1)'(r_y);
        if (ox_full > SAT_HI)
            ox_sat = CW'(SAT_HI);
        else if (ox_full < SAT_LO)
            ox_sat = CW'(SAT_LO);
        else
            ox_sat = CW'(ox_full);
        if (oy_full > SAT_HI)
            oy_sat = CW'(SAT_HI);
        else if (oy_full < SAT_LO)
            oy_sat = CW'(SAT_LO);
        else
            oy_sat = CW'(oy_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= r_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg <= ox_sat;
            out_y_reg <= oy_sat;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.out_x = out_x_reg;
    assign out_ch.out_y = out_y_reg;

endmodule

`default_nettype wire
